### rtl/cma_pkg.sv
package cma_pkg;

	// sample and field widths
	localparam int SMP_W = 16;
	localparam int HW_W  = 3;
	localparam int K_W   = 3;
	localparam int N_W   = 4;

	// largest half width the register can express
	localparam int K_LIM = (1 << K_W) - 1;

	// half width after reset
	localparam logic [HW_W-1:0] HW_RESET = 3'd2;

	// window sum holds up to fifteen samples
	localparam int SUM_W = SMP_W + N_W;

	// reciprocal scaling: ceil(2^RCP_SHIFT / n) is exact for |sum| * n below 2^RCP_SHIFT
	localparam int RCP_SHIFT = 24;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam int unsigned RCP_ONE = 1 << RCP_SHIFT;

	// reciprocal table indexed by window length, entry zero unused
	localparam logic [RCP_W-1:0] RCP_TAB [1 << N_W] = '{
		RCP_W'(0),
		RCP_W'((RCP_ONE + 0) / 1),
		RCP_W'((RCP_ONE + 1) / 2),
		RCP_W'((RCP_ONE + 2) / 3),
		RCP_W'((RCP_ONE + 3) / 4),
		RCP_W'((RCP_ONE + 4) / 5),
		RCP_W'((RCP_ONE + 5) / 6),
		RCP_W'((RCP_ONE + 6) / 7),
		RCP_W'((RCP_ONE + 7) / 8),
		RCP_W'((RCP_ONE + 8) / 9),
		RCP_W'((RCP_ONE + 9) / 10),
		RCP_W'((RCP_ONE + 10) / 11),
		RCP_W'((RCP_ONE + 11) / 12),
		RCP_W'((RCP_ONE + 12) / 13),
		RCP_W'((RCP_ONE + 13) / 14),
		RCP_W'((RCP_ONE + 14) / 15)
	};

	// work handed from the front to the back end
	typedef struct packed {
		logic [N_W-1:0] cnt;    // samples of the stream in the window store
		logic [K_W-1:0] khalf;  // effective half width
		logic [K_W-1:0] lag;    // distance of the first output behind the newest sample
		logic           flush;  // emit every pending output down to distance zero
	} cma_job_t;

endpackage

### rtl/cma_if.sv
interface cma_in_if import cma_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;
	logic                    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] average;
	logic                    last_res;

	modport source (output valid, output average, output last_res, input ready);
	modport sink (input valid, input average, input last_res, output ready);
endinterface

### rtl/cma_front.sv
module cma_front import cma_pkg::*; #(
	parameter int KMAX = 4,
	parameter int WIN  = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [HW_W-1:0]      cfg_wdata,
	cma_in_if.sink               samples,
	input  logic                 q_full,
	output logic                 push,
	output cma_job_t             job,
	output logic [WIN*SMP_W-1:0] win_n
);

	logic [HW_W-1:0]  hw_q;
	logic [SMP_W-1:0] win_q [WIN];
	logic [N_W-1:0]   cnt_q;
	logic [N_W-1:0]   cnt_n;
	logic [K_W-1:0]   gap_q;
	logic [K_W-1:0]   k_eff;
	logic             accept;

	// handshake: an item is taken whenever the queue has room
	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;

	// half width saturates at the largest one the window store supports
	assign k_eff = (hw_q > HW_W'(KMAX)) ? K_W'(KMAX) : K_W'(hw_q);

	// received count saturates at the window depth
	assign cnt_n = (cnt_q < N_W'(WIN)) ? cnt_q + 1'b1 : cnt_q;

	// window after shifting in the new item, entry zero newest
	always_comb begin
		win_n[SMP_W-1:0] = samples.sample;
		for (int a = 1; a < WIN; a++) begin
			win_n[a*SMP_W +: SMP_W] = win_q[a-1];
		end
	end

	// classify: last flushes everything pending, otherwise emit once the gap is full
	assign push       = accept && (samples.last || gap_q >= k_eff);
	assign job.cnt    = cnt_n;
	assign job.khalf  = k_eff;
	assign job.lag    = samples.last ? gap_q : k_eff;
	assign job.flush  = samples.last;

	// configuration and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= HW_RESET;
			cnt_q <= '0;
			gap_q <= '0;
		end else if (cfg_we) begin
			hw_q  <= cfg_wdata;
			cnt_q <= '0;
			gap_q <= '0;
		end else if (accept) begin
			if (samples.last) begin
				cnt_q <= '0;
				gap_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				if (gap_q < k_eff) begin
					gap_q <= gap_q + 1'b1;
				end
			end
		end
	end

	// window store shift line
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < WIN; a++) begin
				win_q[a] <= win_n[a*SMP_W +: SMP_W];
			end
		end
	end

endmodule

### rtl/cma_queue.sv
module cma_queue import cma_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/cma_back.sv
module cma_back import cma_pkg::*; #(
	parameter int WIN = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  cma_job_t             job,
	input  logic [WIN*SMP_W-1:0] win,
	output logic                 pop,
	cma_out_if.source            averages
);

	localparam int GRP    = 6;
	localparam int NG     = (WIN + GRP - 1) / GRP;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam int Q_W    = SMP_W + 1;

	// sequencer
	logic           started_q;
	logic [K_W-1:0] d_q;
	logic [K_W-1:0] d_cur;
	logic [N_W-1:0] reach;
	logic [N_W-1:0] n_cur;
	logic           fin_cur;
	logic           last_op;
	logic           adv;
	logic           issue;

	// masked window elements, padded to whole groups
	logic signed [SMP_W-1:0] elem [NG*GRP];
	logic signed [SUM_W-1:0] grp_n [NG];
	logic signed [SUM_W-1:0] sum_n;
	logic [SUM_W-1:0]        mag_n;
	logic [Q_W-1:0]          qmag;
	logic [Q_W-1:0]          qval;

	// pipeline registers
	logic                    v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic signed [SUM_W-1:0] grp_s1 [NG];
	logic [N_W-1:0]          n_s1, n_s2;
	logic                    fin_s1, fin_s2, fin_s3, fin_s4;
	logic signed [SUM_W-1:0] sum_s2;
	logic [SUM_W-1:0]        mag_s3;
	logic [RCP_W-1:0]        rcp_s3;
	logic                    neg_s3, neg_s4;
	logic [PROD_W-1:0]       prod_s4;
	logic [SMP_W-1:0]        avg_q;
	logic                    last_q;

	// the whole pipeline moves when the output register is free or being taken
	assign adv   = !out_valid_q || averages.ready;
	assign issue = adv && job_valid;

	// current output distance and its window length
	assign d_cur   = started_q ? d_q : job.lag;
	assign reach   = N_W'(d_cur) + N_W'(job.khalf) + 1'b1;
	assign n_cur   = (job.cnt < reach) ? job.cnt : reach;
	assign fin_cur = job.flush && (d_cur == '0);
	assign last_op = !job.flush || (d_cur == '0);
	assign pop     = issue && last_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			d_q       <= '0;
		end else if (issue) begin
			if (last_op) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				d_q       <= d_cur - 1'b1;
			end
		end
	end

	// keep only the newest n samples
	for (genvar a = 0; a < NG*GRP; a++) begin : g_elem
		if (a < WIN) begin : g_in
			assign elem[a] = (N_W'(a) < n_cur) ? signed'(win[a*SMP_W +: SMP_W]) : '0;
		end else begin : g_pad
			assign elem[a] = '0;
		end
	end

	// first level of the adder tree
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_n[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				grp_n[g] = grp_n[g] + SUM_W'(elem[g*GRP + j]);
			end
		end
	end

	// second level of the adder tree
	always_comb begin
		sum_n = '0;
		for (int g = 0; g < NG; g++) begin
			sum_n = sum_n + grp_s1[g];
		end
	end

	// magnitude for division toward zero
	assign mag_n = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);

	// quotient from the scaled product, sign restored
	assign qmag = prod_s4[RCP_SHIFT +: Q_W];
	assign qval = neg_s4 ? Q_W'(0) - qmag : qmag;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			grp_s1  <= grp_n;
			n_s1    <= n_cur;
			fin_s1  <= fin_cur;
			sum_s2  <= sum_n;
			n_s2    <= n_s1;
			fin_s2  <= fin_s1;
			mag_s3  <= mag_n;
			neg_s3  <= sum_s2[SUM_W-1];
			rcp_s3  <= RCP_TAB[n_s2];
			fin_s3  <= fin_s2;
			prod_s4 <= mag_s3 * rcp_s3;
			neg_s4  <= neg_s3;
			fin_s4  <= fin_s3;
			avg_q   <= qval[SMP_W-1:0];
			last_q  <= fin_s4;
		end
	end

	assign averages.valid    = out_valid_q;
	assign averages.average  = signed'(avg_q);
	assign averages.last_res = last_q;

endmodule

### rtl/centered_moving_average.sv
// a job passes the queue, back end stages s1 to s4 and the output register to averages
// throughput: one item per cycle while the queue has room; a last item yields up to K+1
//   results, one window mean per cycle from the back end while averages is ready
// a two-entry job queue lets the input run ahead of the back end until it fills
// reset: arst_n clears all control state and sets the half width to 2; the window
//   store is not cleared, only samples of the current stream are ever summed
module centered_moving_average import cma_pkg::*; #(
	parameter int MAX_HALF = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [HW_W-1:0] cfg_wdata,
	cma_in_if.sink          samples,
	cma_out_if.source       averages
);

	localparam int KMAX    = (MAX_HALF < K_LIM) ? MAX_HALF : K_LIM;
	localparam int WIN     = 2 * KMAX + 1;
	localparam int WIN_W   = WIN * SMP_W;
	localparam int JOB_W   = $bits(cma_job_t);
	localparam int Q_DEPTH = 2;

	logic               push;
	logic               q_full;
	logic               q_valid;
	logic               pop;
	cma_job_t           job_in;
	cma_job_t           job_hd;
	logic [WIN_W-1:0]   win_in;
	logic [WIN_W-1:0]   win_hd;
	logic [JOB_W+WIN_W-1:0] q_head;

	// front: window store, counters, job classification
	cma_front #(
		.KMAX (KMAX),
		.WIN  (WIN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.q_full    (q_full),
		.push      (push),
		.job       (job_in),
		.win_n     (win_in)
	);

	// job queue between front and back
	cma_queue #(
		.DATA_W (JOB_W + WIN_W),
		.DEPTH  (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({job_in, win_in}),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (q_head)
	);

	assign job_hd = q_head[JOB_W+WIN_W-1:WIN_W];
	assign win_hd = q_head[WIN_W-1:0];

	// back: window sums and division
	cma_back #(
		.WIN (WIN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (job_hd),
		.win       (win_hd),
		.pop       (pop),
		.averages  (averages)
	);

endmodule

### rtl/cma_checker.sv
module cma_checker import cma_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_last,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SMP_W-1:0] out_average,
	input logic             out_last
);

	logic [3:0] pend_q;
	logic       seen_q;
	logic       in_fin;
	logic       out_fin;

	assign in_fin  = in_valid && in_ready && in_last;
	assign out_fin = out_valid && out_ready && out_last;

	// last items whose final result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			seen_q <= 1'b0;
		end else begin
			case ({in_fin, out_fin})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
			if (in_valid && in_ready) begin
				seen_q <= 1'b1;
			end
		end
	end

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_last))
		else $error("result changed while stalled");

	// a final result needs a last item that has not been answered yet
	a_fin_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> pend_q != '0)
		else $error("final result without pending last item");

	// no result before any item was taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result before any item");

endmodule

bind centered_moving_average cma_checker u_cma_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.in_last     (samples.last),
	.out_valid   (averages.valid),
	.out_ready   (averages.ready),
	.out_average (averages.average),
	.out_last    (averages.last_res)
);

### tb/tb_top.sv
module tb_top;
	import cma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_HALF     = 4;
	localparam int WIN_DEPTH    = 2 * MAX_HALF + 1;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic signed [SMP_W-1:0] average;
		logic                    last_res;
	} avg_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [HW_W-1:0] cfg_wdata;

	cma_in_if  in_if ();
	cma_out_if out_if ();

	centered_moving_average #(
		.MAX_HALF(MAX_HALF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samples  (in_if),
		.averages (out_if)
	);

	// shadow copy of the smoothing state
	logic [HW_W-1:0]         half_width_q;
	logic signed [SMP_W-1:0] window_q [WIN_DEPTH];
	int unsigned             rx_count;
	int unsigned             pending_outs;

	avg_item_t expected_avgs [$];
	int        errors;
	int        burst_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver stalls, a new random pattern and mode drawn once each pattern has been played out
	initial begin
		logic [31:0] pat;
		int unsigned mode;
		out_if.ready = 1'b0;
		forever begin
			pat  = $urandom;
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 32; i++) begin
				@(negedge clk);
				case (mode)
					0: begin
						out_if.ready <= 1'b1;
					end
					1: begin
						out_if.ready <= pat[i];
					end
					2: begin
						out_if.ready <= pat[i] & pat[(i + 7) % 32];
					end
					default: begin
						out_if.ready <= pat[i] | pat[(i + 3) % 32];
					end
				endcase
			end
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		avg_item_t want;
		if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			if (expected_avgs.size() == 0) begin
				$error("unexpected result: average %0d last_res %0b",
					out_if.average, out_if.last_res);
				errors++;
			end else begin
				want = expected_avgs.pop_front();
				if (out_if.average !== want.average) begin
					$error("average: expected %0d, got %0d", want.average, out_if.average);
					errors++;
				end
				if (out_if.last_res !== want.last_res) begin
					$error("last_res: expected %0b, got %0b", want.last_res, out_if.last_res);
					errors++;
				end
			end
		end
	end

	function automatic int unsigned eff_half();
		return (half_width_q > MAX_HALF) ? MAX_HALF : int'(half_width_q);
	endfunction

	// mean of the newest n samples, truncated toward zero
	function automatic void push_window_mean(int unsigned n, logic fin);
		int        sum;
		avg_item_t r;
		sum = 0;
		if (n > rx_count)
			n = rx_count;
		for (int a = 0; a < n; a++)
			sum += window_q[a];
		r.average  = SMP_W'(sum / int'(n));
		r.last_res = fin;
		expected_avgs.insert(expected_avgs.size(), r);
	endfunction

	function automatic void predict_sample(logic signed [SMP_W-1:0] s, logic l);
		int unsigned k;
		int          d;
		k = eff_half();
		for (int a = WIN_DEPTH - 1; a > 0; a--)
			window_q[a] = window_q[a - 1];
		window_q[0] = s;
		if (rx_count < WIN_DEPTH)
			rx_count++;
		if (!l) begin
			if (pending_outs < k)
				pending_outs++;
			else
				push_window_mean(2 * k + 1, 1'b0);
		end else begin
			// flush every pending output, newest window last
			for (d = int'(pending_outs); d >= 0; d--)
				push_window_mean(d + k + 1, d == 0);
			rx_count     = 0;
			pending_outs = 0;
		end
	endfunction

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SMP_W'($urandom_range(0, 7)) - 16'sd4;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// send one item, with bursts and random gaps
	task automatic send_sample(input logic signed [SMP_W-1:0] s, input logic l);
		@(negedge clk);
		if (burst_left <= 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		in_if.valid  <= 1'b1;
		in_if.sample <= s;
		in_if.last   <= l;
		do
			@(posedge clk);
		while (in_if.ready !== 1'b1);
		predict_sample(s, l);
		burst_left--;
	endtask

	// stop sending and wait until the block has gone quiet
	task automatic drain();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_avgs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_half_width(input logic [HW_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		half_width_q = v;
		rx_count     = 0;
		pending_outs = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// reset half width with a mixed stream
	task automatic test_reset_width();
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(16'sh7ffe, 1'b1);
		drain();
	endtask

	task automatic test_single_sample();
		send_sample(-16'sd12345, 1'b1);
		drain();
	endtask

	// zero half width passes samples straight through
	task automatic test_zero_width();
		write_half_width(3'd0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh5a5a, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		drain();
	endtask

	// width above the limit saturates, full window of extremes
	task automatic test_saturated_width();
		write_half_width(3'd7);
		for (int i = 0; i < WIN_DEPTH; i++)
			send_sample(16'sh8000, i == WIN_DEPTH - 1);
		drain();
	endtask

	// stream ends before the first window fills
	task automatic test_short_stream();
		write_half_width(3'd4);
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd33, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		drain();
	endtask

	// register write in the middle of a stream drops its pending outputs
	task automatic test_abandoned_stream();
		write_half_width(3'd3);
		send_sample(16'sd11, 1'b0);
		send_sample(16'sd22, 1'b0);
		send_sample(16'sd33, 1'b0);
		write_half_width(3'd1);
		send_sample(-16'sd5, 1'b0);
		send_sample(16'sd9, 1'b1);
		drain();
	endtask

	// random streams, widths changed between and sometimes inside streams
	task automatic test_random_streams();
		int unsigned sent;
		int unsigned len;
		logic        abandon;
		sent = 0;
		while (sent < 100) begin
			if ($urandom_range(0, 2) == 0)
				write_half_width(HW_W'($urandom_range(0, 7)));
			len     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 16);
			abandon = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < len; i++) begin
				send_sample(rand_sample(), !abandon && i == len - 1);
				sent++;
			end
			if (abandon)
				write_half_width(HW_W'($urandom_range(0, 7)));
		end
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_if.valid   = 1'b0;
		in_if.sample  = '0;
		in_if.last    = 1'b0;
		errors        = 0;
		burst_left    = 0;
		half_width_q  = HW_RESET;
		rx_count      = 0;
		pending_outs  = 0;
		for (int a = 0; a < WIN_DEPTH; a++)
			window_q[a] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_width();
		test_single_sample();
		test_zero_width();
		test_saturated_width();
		test_short_stream();
		test_abandoned_stream();
		test_random_streams();

		if (expected_avgs.size() != 0) begin
			$error("%0d expected results never arrived", expected_avgs.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/cma_pkg.sv
rtl/cma_if.sv
rtl/cma_front.sv
rtl/cma_queue.sv
rtl/cma_back.sv
rtl/centered_moving_average.sv
rtl/cma_checker.sv
tb/tb_top.sv
